/* design/tgarle_pkg.sv */
package tgarle_pkg;

   localparam int PIX_W            = 24;
   localparam int HDR_W            = 8;
   localparam int COL_W            = 16;
   localparam int CNT_W            = 2;
   localparam logic [COL_W-1:0] LINE_WIDTH_RESET = 16'd640;

   // controller to datapath
   typedef struct packed {
      logic accept;       // pixel word taken this cycle
      logic flush_init;   // start a packet flush
      logic rd_issue;     // read literal buffer at current index
      logic rd_take;      // capture read data into result slot
      logic emit_run;     // load run result into output register
      logic emit_lit;     // load literal result into output register
      logic flush_clear;  // packet closed, back to empty
      logic open_pend;    // open packet with the held pixel
      logic mark_line;    // this flush is the last of the step
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic brk;          // incoming pixel breaks the open packet
      logic need_flush;   // packet full or line end after update
      logic mode_run;     // open packet is a run
      logic group_full;   // slot group complete after this capture
      logic lit_done;     // all literal pixels emitted
      logic out_free;     // output register can load
      logic line_end;     // held line end flag of the step
   } status_type;

endpackage

/* design/tga_rle_line_encoder_unit.sv */
// Pixel that closes no packet: accepted in the cycle it is offered, next pixel the cycle after.
// Run packet flush: S_FLUSH, then S_RUN_EMIT loads the result once the output is free.
// Literal flush: S_READ and S_TAKE per pixel, set by the buffer's single registered read
// port, S_LIT_EMIT per word of up to three; a broken packet adds S_OPEN to open the next one.
// Reset (synchronous): line width 640, no open packet, column 0; the literal
// buffer is not cleared, every entry is written before it is read.
module tga_rle_line_encoder_unit
   import tgarle_pkg::*;
#(
   parameter int MAX_PACKET = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [COL_W-1:0] csr_write_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_pixel_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_has_header,
   output logic [HDR_W-1:0] rsp_header_byte,
   output logic [CNT_W-1:0] rsp_pixel_count,
   output logic [PIX_W-1:0] rsp_pixel_first,
   output logic [PIX_W-1:0] rsp_pixel_second,
   output logic [PIX_W-1:0] rsp_pixel_third,
   output logic             rsp_packet_done,
   output logic             rsp_line_done
);

   cmd_type    cmd;
   status_type status;

   tgarle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tgarle_dpath #(
      .MAX_PACKET (MAX_PACKET)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_pixel_value  (req_pixel_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_has_header   (rsp_has_header),
      .rsp_header_byte  (rsp_header_byte),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pixel_third  (rsp_pixel_third),
      .rsp_packet_done  (rsp_packet_done),
      .rsp_line_done    (rsp_line_done),
      .cmd              (cmd),
      .status           (status)
   );

   // a result word always carries at least one pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_count != 2'd0)
      else $error("result word with no pixels");

   // run results are single words: header, one pixel, packet end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_header_byte[7]) |->
         (rsp_has_header && rsp_packet_done && rsp_pixel_count == 2'd1))
      else $error("malformed run result");

   // a line never ends inside a packet
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_done) |-> rsp_packet_done)
      else $error("line end inside a packet");

   // header byte is zero on continuation words
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_header) |-> (rsp_header_byte == 8'd0))
      else $error("header byte set without header");

endmodule

/* design/tgarle_ram.sv */
module tgarle_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tgarle_ctrl.sv */
module tgarle_ctrl
   import tgarle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FLUSH,
      S_RUN_EMIT,
      S_READ,
      S_TAKE,
      S_LIT_EMIT,
      S_OPEN
   } state_type;

   state_type state_ff, state_in;
   logic      brk_phase_ff, brk_phase_in;

   // next state and command decode
   always_comb begin
      state_in      = state_ff;
      brk_phase_in  = brk_phase_ff;
      cmd           = '0;
      cmd.mark_line = !brk_phase_ff;
      req_stall     = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept   = 1'b1;
               brk_phase_in = status.brk;
               if (status.brk || status.need_flush) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            cmd.flush_init = 1'b1;
            state_in       = status.mode_run ? S_RUN_EMIT : S_READ;
         end
         S_RUN_EMIT: begin
            if (status.out_free) begin
               cmd.emit_run    = 1'b1;
               cmd.flush_clear = 1'b1;
               state_in        = brk_phase_ff ? S_OPEN : S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_TAKE;
         end
         S_TAKE: begin
            cmd.rd_take = 1'b1;
            state_in    = status.group_full ? S_LIT_EMIT : S_READ;
         end
         S_LIT_EMIT: begin
            if (status.out_free) begin
               cmd.emit_lit = 1'b1;
               if (status.lit_done) begin
                  cmd.flush_clear = 1'b1;
                  state_in        = brk_phase_ff ? S_OPEN : S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_OPEN: begin
            // broken packet sent; the held pixel opens the next one
            cmd.open_pend = 1'b1;
            if (status.line_end) begin
               brk_phase_in = 1'b0;
               state_in     = S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         brk_phase_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         brk_phase_ff <= brk_phase_in;
      end
   end

endmodule

/* design/tgarle_dpath.sv */
module tgarle_dpath
   import tgarle_pkg::*;
#(
   parameter int MAX_PACKET = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [COL_W-1:0] csr_write_data,
   input  logic [PIX_W-1:0] req_pixel_value,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic             rsp_has_header,
   output logic [HDR_W-1:0] rsp_header_byte,
   output logic [CNT_W-1:0] rsp_pixel_count,
   output logic [PIX_W-1:0] rsp_pixel_first,
   output logic [PIX_W-1:0] rsp_pixel_second,
   output logic [PIX_W-1:0] rsp_pixel_third,
   output logic             rsp_packet_done,
   output logic             rsp_line_done,
   input  cmd_type          cmd,
   output status_type       status
);

   localparam int LEN_W  = $clog2(MAX_PACKET + 1);
   localparam int ADDR_W = $clog2(MAX_PACKET);

   typedef enum logic [1:0] {
      MODE_EMPTY,
      MODE_SINGLE,
      MODE_RUN,
      MODE_LIT
   } mode_type;

   logic [COL_W-1:0]  line_width_ff;
   mode_type          mode_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [PIX_W-1:0]  prev_ff;
   logic [COL_W-1:0]  col_ff;
   logic [PIX_W-1:0]  pend_ff;
   logic              line_end_ff;

   logic [LEN_W-1:0]  rd_idx_ff;
   logic [CNT_W-1:0]  slot_cnt_ff;
   logic [PIX_W-1:0]  slot_ff [3];
   logic              hdr_pend_ff;

   logic              rsp_valid_ff;
   logic              rsp_has_header_ff;
   logic [HDR_W-1:0]  rsp_header_byte_ff;
   logic [CNT_W-1:0]  rsp_pixel_count_ff;
   logic [PIX_W-1:0]  rsp_pixel_first_ff;
   logic [PIX_W-1:0]  rsp_pixel_second_ff;
   logic [PIX_W-1:0]  rsp_pixel_third_ff;
   logic              rsp_packet_done_ff;
   logic              rsp_line_done_ff;

   logic              pix_eq;
   logic [COL_W:0]    next_col;
   logic              line_end;
   logic              brk;
   logic              acc_wr;
   logic [LEN_W-1:0]  len_new;
   mode_type          mode_new;
   logic              prev_upd;
   logic [LEN_W-1:0]  flush_len;
   logic [LEN_W-1:0]  len_m1;
   logic [LEN_W-1:0]  flush_m1;
   logic              out_free;
   logic              lit_done;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [PIX_W-1:0]  ram_wr_data;
   logic [PIX_W-1:0]  ram_rd_data;

   // column and line end for the incoming pixel
   assign next_col = {1'b0, col_ff} + {{COL_W{1'b0}}, 1'b1};
   assign line_end = next_col >= {1'b0, line_width_ff};
   assign pix_eq   = (req_pixel_value == prev_ff);

   // packet update decision for the incoming pixel
   always_comb begin
      brk      = 1'b0;
      acc_wr   = 1'b0;
      len_new  = len_ff;
      mode_new = mode_ff;
      prev_upd = 1'b0;
      unique case (mode_ff)
         MODE_EMPTY: begin
            acc_wr   = 1'b1;
            len_new  = LEN_W'(1);
            mode_new = MODE_SINGLE;
            prev_upd = 1'b1;
         end
         MODE_SINGLE: begin
            len_new = LEN_W'(2);
            if (pix_eq) begin
               mode_new = MODE_RUN;
            end else begin
               mode_new = MODE_LIT;
               acc_wr   = 1'b1;
               prev_upd = 1'b1;
            end
         end
         MODE_RUN: begin
            if (pix_eq) begin
               len_new = len_ff + LEN_W'(1);
            end else begin
               brk = 1'b1;
            end
         end
         MODE_LIT: begin
            if (!pix_eq) begin
               acc_wr   = 1'b1;
               len_new  = len_ff + LEN_W'(1);
               prev_upd = 1'b1;
            end else begin
               brk = 1'b1;
            end
         end
         default: begin
            brk = 1'b0;
         end
      endcase
   end

   assign flush_len = (mode_ff == MODE_SINGLE) ? LEN_W'(1) : len_ff;
   assign len_m1    = len_ff - LEN_W'(1);
   assign flush_m1  = flush_len - LEN_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign lit_done  = (rd_idx_ff == flush_len);

   // status to controller
   always_comb begin
      status            = '0;
      status.brk        = brk;
      status.need_flush = line_end || (len_new >= LEN_W'(MAX_PACKET));
      status.mode_run   = (mode_ff == MODE_RUN);
      status.group_full = (slot_cnt_ff == 2'd2) ||
                          ((rd_idx_ff + LEN_W'(1)) == flush_len);
      status.lit_done   = lit_done;
      status.out_free   = out_free;
      status.line_end   = line_end_ff;
   end

   // literal buffer write port
   always_comb begin
      ram_we      = 1'b0;
      ram_wr_addr = len_ff[ADDR_W-1:0];
      ram_wr_data = req_pixel_value;
      if (cmd.open_pend) begin
         ram_we      = 1'b1;
         ram_wr_addr = '0;
         ram_wr_data = pend_ff;
      end else if (cmd.accept && acc_wr) begin
         ram_we = 1'b1;
         if (mode_ff == MODE_EMPTY) begin
            ram_wr_addr = '0;
         end
      end
   end

   tgarle_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_PACKET)
   ) u_lit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // packet and column state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         mode_ff       <= MODE_EMPTY;
         len_ff        <= '0;
         prev_ff       <= '0;
         col_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            line_width_ff <= csr_write_data;
         end
         if (cmd.accept) begin
            col_ff <= line_end ? '0 : next_col[COL_W-1:0];
            if (!brk) begin
               mode_ff <= mode_new;
               len_ff  <= len_new;
               if (prev_upd) begin
                  prev_ff <= req_pixel_value;
               end
            end
         end else if (cmd.flush_clear) begin
            mode_ff <= MODE_EMPTY;
            len_ff  <= '0;
         end else if (cmd.open_pend) begin
            mode_ff <= MODE_SINGLE;
            len_ff  <= LEN_W'(1);
            prev_ff <= pend_ff;
         end
      end
   end

   // held pixel, line end flag and literal gather slots
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_ff     <= req_pixel_value;
         line_end_ff <= line_end;
      end
      if (cmd.flush_init || cmd.emit_lit) begin
         slot_cnt_ff <= '0;
         slot_ff[0]  <= '0;
         slot_ff[1]  <= '0;
         slot_ff[2]  <= '0;
      end else if (cmd.rd_take) begin
         slot_ff[slot_cnt_ff] <= ram_rd_data;
         slot_cnt_ff          <= slot_cnt_ff + 2'd1;
      end
      if (cmd.flush_init) begin
         rd_idx_ff   <= '0;
         hdr_pend_ff <= 1'b1;
      end else begin
         if (cmd.rd_take) begin
            rd_idx_ff <= rd_idx_ff + LEN_W'(1);
         end
         if (cmd.emit_lit) begin
            hdr_pend_ff <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_run || cmd.emit_lit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_run) begin
         rsp_has_header_ff   <= 1'b1;
         rsp_header_byte_ff  <= {1'b1, 7'(len_m1)};
         rsp_pixel_count_ff  <= 2'd1;
         rsp_pixel_first_ff  <= prev_ff;
         rsp_pixel_second_ff <= '0;
         rsp_pixel_third_ff  <= '0;
         rsp_packet_done_ff  <= 1'b1;
         rsp_line_done_ff    <= cmd.mark_line && line_end_ff;
      end else if (cmd.emit_lit) begin
         rsp_has_header_ff   <= hdr_pend_ff;
         rsp_header_byte_ff  <= hdr_pend_ff ? {1'b0, 7'(flush_m1)} : '0;
         rsp_pixel_count_ff  <= slot_cnt_ff;
         rsp_pixel_first_ff  <= slot_ff[0];
         rsp_pixel_second_ff <= slot_ff[1];
         rsp_pixel_third_ff  <= slot_ff[2];
         rsp_packet_done_ff  <= lit_done;
         rsp_line_done_ff    <= lit_done && cmd.mark_line && line_end_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_has_header   = rsp_has_header_ff;
   assign rsp_header_byte  = rsp_header_byte_ff;
   assign rsp_pixel_count  = rsp_pixel_count_ff;
   assign rsp_pixel_first  = rsp_pixel_first_ff;
   assign rsp_pixel_second = rsp_pixel_second_ff;
   assign rsp_pixel_third  = rsp_pixel_third_ff;
   assign rsp_packet_done  = rsp_packet_done_ff;
   assign rsp_line_done    = rsp_line_done_ff;

endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tgarle_pkg::*;

   localparam int MAX_PACKET    = 128;
   localparam int SETTLE_CYCLES = 24;    // covers the open-next-packet state and output reg
   localparam int STALL_LIMIT   = 3000;  // cycles with no word moving on either side
   localparam int PRINT_LIMIT   = 40;

   // one result word as it leaves the encoder
   typedef struct packed {
      logic             has_header;
      logic [HDR_W-1:0] header_byte;
      logic [CNT_W-1:0] pixel_count;
      logic [PIX_W-1:0] pixel_first;
      logic [PIX_W-1:0] pixel_second;
      logic [PIX_W-1:0] pixel_third;
      logic             packet_done;
      logic             line_done;
   } rle_word_type;

   typedef enum logic [1:0] {PK_EMPTY, PK_SINGLE, PK_RUN, PK_LIT} pk_mode_type;

   typedef struct {
      bit               set_width;
      logic [COL_W-1:0] width;
      logic [PIX_W-1:0] pixel;
      bit               typed;
      rle_word_type     want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable = 1'b0;
   logic [COL_W-1:0] csr_write_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [PIX_W-1:0] req_pixel_value = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_has_header;
   logic [HDR_W-1:0] rsp_header_byte;
   logic [CNT_W-1:0] rsp_pixel_count;
   logic [PIX_W-1:0] rsp_pixel_first;
   logic [PIX_W-1:0] rsp_pixel_second;
   logic [PIX_W-1:0] rsp_pixel_third;
   logic             rsp_packet_done;
   logic             rsp_line_done;

   // encoder state mirror
   pk_mode_type      pk_mode = PK_EMPTY;
   logic [7:0]       pk_len = '0;
   logic [PIX_W-1:0] pk_prev = '0;
   logic [PIX_W-1:0] lit_buf [MAX_PACKET];
   logic [COL_W-1:0] col_pos = '0;
   logic [COL_W-1:0] line_width = LINE_WIDTH_RESET;

   rle_word_type     step_words[$];
   rle_word_type     expected_words[$];
   logic [PIX_W-1:0] last_pixel = '0;
   bit               idle_on = 1'b1;
   int               mismatch_count = 0;
   int               words_seen = 0;
   int               quiet_cycles = 0;

   tga_rle_line_encoder_unit #(
      .MAX_PACKET(MAX_PACKET)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_has_header  (rsp_has_header),
      .rsp_header_byte (rsp_header_byte),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_pixel_first (rsp_pixel_first),
      .rsp_pixel_second(rsp_pixel_second),
      .rsp_pixel_third (rsp_pixel_third),
      .rsp_packet_done (rsp_packet_done),
      .rsp_line_done   (rsp_line_done)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Packet predictor
   // ---------------------------------------------------------------

   // emit the open packet: one word for a run, one per three literal pixels
   task automatic close_packet();
      int           n;
      int           cnt;
      rle_word_type w;
      n = (pk_mode == PK_SINGLE) ? 1 : int'(pk_len);
      if (pk_mode == PK_RUN) begin
         w = '0;
         w.has_header  = 1'b1;
         w.header_byte = {1'b1, 7'(pk_len - 8'd1)};
         w.pixel_count = 2'd1;
         w.pixel_first = pk_prev;
         w.packet_done = 1'b1;
         step_words.push_back(w);
      end else if (pk_mode != PK_EMPTY) begin
         for (int i = 0; i < n; i += 3) begin
            cnt = (n - i > 3) ? 3 : n - i;
            w = '0;
            w.has_header   = (i == 0);
            w.header_byte  = (i == 0) ? {1'b0, 7'(n - 1)} : '0;
            w.pixel_count  = CNT_W'(cnt);
            w.pixel_first  = lit_buf[i];
            w.pixel_second = (cnt > 1) ? lit_buf[i + 1] : '0;
            w.pixel_third  = (cnt > 2) ? lit_buf[i + 2] : '0;
            w.packet_done  = (i + cnt >= n);
            step_words.push_back(w);
         end
      end
      pk_mode = PK_EMPTY;
      pk_len  = '0;
   endtask

   task automatic open_packet(input logic [PIX_W-1:0] p);
      pk_mode    = PK_SINGLE;
      pk_len     = 8'd1;
      pk_prev    = p;
      lit_buf[0] = p;
   endtask

   // words caused by one accepted pixel, left in step_words
   task automatic encode_pixel(input logic [PIX_W-1:0] p);
      logic [COL_W:0] next_col;
      bit             line_end;
      step_words.delete();
      case (pk_mode)
         PK_EMPTY: begin
            open_packet(p);
         end
         PK_SINGLE: begin
            if (p == pk_prev) begin
               pk_mode = PK_RUN;
            end else begin
               pk_mode    = PK_LIT;
               lit_buf[1] = p;
               pk_prev    = p;
            end
            pk_len = 8'd2;
         end
         PK_RUN: begin
            if (p == pk_prev) begin
               pk_len = pk_len + 8'd1;
            end else begin
               close_packet();
               open_packet(p);
            end
         end
         default: begin
            if (p != pk_prev) begin
               lit_buf[pk_len[6:0]] = p;
               pk_len  = pk_len + 8'd1;
               pk_prev = p;
            end else begin
               close_packet();
               open_packet(p);
            end
         end
      endcase

      // column tracking; width 0 acts as width 1
      next_col = {1'b0, col_pos} + (COL_W + 1)'(1);
      line_end = (next_col >= {1'b0, line_width});
      col_pos  = line_end ? '0 : next_col[COL_W-1:0];

      if (int'(pk_len) >= MAX_PACKET || line_end)
         close_packet();
      if (line_end && step_words.size() > 0)
         step_words[step_words.size() - 1].line_done = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [PIX_W-1:0] got,
                                input logic [PIX_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s: got %h, want %h",
                                   words_seen, name, got, want));
   endtask

   task automatic check_word(input rle_word_type got);
      rle_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("word %0d not expected: %h", words_seen, got));
         return;
      end
      want = expected_words.pop_front();
      compare_field("has_header",   PIX_W'(got.has_header),  PIX_W'(want.has_header));
      compare_field("header_byte",  PIX_W'(got.header_byte), PIX_W'(want.header_byte));
      compare_field("pixel_count",  PIX_W'(got.pixel_count), PIX_W'(want.pixel_count));
      compare_field("pixel_first",  got.pixel_first,         want.pixel_first);
      compare_field("pixel_second", got.pixel_second,        want.pixel_second);
      compare_field("pixel_third",  got.pixel_third,         want.pixel_third);
      compare_field("packet_done",  PIX_W'(got.packet_done), PIX_W'(want.packet_done));
      compare_field("line_done",    PIX_W'(got.line_done),   PIX_W'(want.line_done));
   endtask

   // result side
   always @(posedge clock) begin : rsp_monitor
      rle_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_has_header, rsp_header_byte, rsp_pixel_count, rsp_pixel_first,
                rsp_pixel_second, rsp_pixel_third, rsp_packet_done, rsp_line_done};
         check_word(got);
         words_seen++;
      end
   end

   // random back-pressure
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 23);
   end

   // watchdog: no word moved on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tga_rle_line_encoder_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------

   function automatic rle_word_type lone_word(input logic [PIX_W-1:0] p);
      lone_word = '{1'b1, 8'h00, 2'd1, p, 24'h0, 24'h0, 1'b1, 1'b1};
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] palette [4] = '{24'h000000, 24'hFFFFFF, 24'h800001, 24'h7FFFFE};
      if ($urandom_range(0, 2) == 0)
         return palette[$urandom_range(0, 3)];
      return PIX_W'($urandom());
   endfunction

   function automatic logic [PIX_W-1:0] distinct_from(input logic [PIX_W-1:0] p);
      logic [PIX_W-1:0] q;
      q = rand_pixel();
      if (q == p)
         q[$urandom_range(0, PIX_W - 1)] = ~p[0];
      if (q == p)
         q = ~p;
      return q;
   endfunction

   // drive one pixel word and record what it should produce
   task automatic send_pixel(input logic [PIX_W-1:0] p, input bit typed = 1'b0,
                             input rle_word_type want = '0);
      // idle cycles decided one at a time
      while (idle_on && $urandom_range(0, 99) < 23) begin
         req_valid       <= 1'b0;
         req_pixel_value <= PIX_W'($urandom());
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= p;
      do @(posedge clock); while (req_stall);
      encode_pixel(p);
      if (typed) begin
         expected_words.push_back(want);
      end else begin
         foreach (step_words[i])
            expected_words.push_back(step_words[i]);
      end
      last_pixel = p;
   endtask

   // stop sending and let every pending word come out
   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_width(input logic [COL_W-1:0] w);
      quiesce();
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= COL_W'($urandom());
      line_width = w;
   endtask

   // a run, a literal stretch, or a few pixels from a small palette
   task automatic send_segment(output int sent);
      int               kind;
      logic [PIX_W-1:0] p;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         sent = $urandom_range(1, 6);
         p = ($urandom_range(0, 3) == 0) ? last_pixel : rand_pixel();
         repeat (sent) send_pixel(p);
      end else if (kind < 8) begin
         sent = $urandom_range(1, 8);
         repeat (sent) send_pixel(distinct_from(last_pixel));
      end else begin
         sent = $urandom_range(1, 4);
         repeat (sent) send_pixel(rand_pixel() & 24'h800001);
      end
   endtask

   task automatic run_phase(input logic [COL_W-1:0] w, input int items);
      int count;
      int sent;
      write_line_width(w);
      count = 0;
      while (count < items) begin
         send_segment(sent);
         count += sent;
      end
   endtask

   initial begin : stimulus
      stim_row_type rows [19];

      // lone pixels at width 1 and 0, then runs, literals and split pairs
      rows = '{
         '{1'b1, 16'd1, 24'h000000, 1'b1, lone_word(24'h000000)},
         '{1'b0, 16'd0, 24'hFFFFFF, 1'b1, lone_word(24'hFFFFFF)},
         '{1'b0, 16'd0, 24'hAAAAAA, 1'b1, lone_word(24'hAAAAAA)},
         '{1'b0, 16'd0, 24'h555555, 1'b1, lone_word(24'h555555)},
         '{1'b1, 16'd0, 24'h123456, 1'b1, lone_word(24'h123456)},
         '{1'b1, 16'd8, 24'h0A0A0A, 1'b0, '0},
         '{1'b0, 16'd0, 24'h0A0A0A, 1'b0, '0},
         '{1'b0, 16'd0, 24'h0A0A0A, 1'b0, '0},
         '{1'b0, 16'd0, 24'hB00001, 1'b0, '0},
         '{1'b0, 16'd0, 24'hC00002, 1'b0, '0},
         '{1'b0, 16'd0, 24'hD00003, 1'b0, '0},
         '{1'b0, 16'd0, 24'hD00003, 1'b0, '0},
         '{1'b0, 16'd0, 24'hE00004, 1'b0, '0},
         '{1'b0, 16'd0, 24'h777777, 1'b0, '0},
         '{1'b0, 16'd0, 24'h777777, 1'b0, '0},
         '{1'b0, 16'd0, 24'h888888, 1'b0, '0},
         '{1'b0, 16'd0, 24'h999999, 1'b0, '0},
         '{1'b0, 16'd0, 24'h999999, 1'b0, '0},
         // width dropped below the column mid-line
         '{1'b1, 16'd3, 24'h999999, 1'b0, '0}
      };

      for (int i = 0; i < MAX_PACKET; i++)
         lit_buf[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].set_width)
            write_line_width(rows[i].width);
         send_pixel(rows[i].pixel, rows[i].typed, rows[i].want);
      end

      // random segments over several line widths
      run_phase(16'd5, 14);
      run_phase(16'd2, 14);
      run_phase(COL_W'($urandom_range(3, 40)), 14);
      run_phase(16'hFFFF, 14);
      idle_on = 1'b0;
      run_phase(16'd12, 14);
      idle_on = 1'b1;

      quiesce();
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("tga_rle_line_encoder_unit test passed");
      end else begin
         $display("tga_rle_line_encoder_unit test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/tgarle_pkg.sv
design/tgarle_ram.sv
design/tgarle_ctrl.sv
design/tgarle_dpath.sv
design/tga_rle_line_encoder_unit.sv
verif/testbench.sv
